>>> sv/acsf_pkg.sv
package acsf_pkg;

	localparam int SLOT_W   = 6;
	localparam int SLOT_SPAN = 2 ** SLOT_W;
	localparam int IDX_W    = SLOT_W + 1;
	localparam int POS_W    = 16;
	localparam int SIZE_W   = 12;
	localparam int VEL_W    = 16;
	localparam int MASK_W   = 5;
	localparam int TAG_W    = 8;
	localparam int MARGIN_W = 8;
	localparam int EXT_W    = 18;
	localparam int SLACK_W  = 17;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam logic [IDX_W-1:0]    NO_SLOT    = IDX_W'(SLOT_SPAN);
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd12;
	localparam int                  VY_SLACK   = 512;

	// register word index on the configuration port
	localparam logic [0:0] REG_MARGIN = 1'b0;

	// solid mask bit positions
	localparam int MASK_SOLID  = 0;
	localparam int MASK_TOP    = 1;
	localparam int MASK_LEFT   = 2;
	localparam int MASK_RIGHT  = 3;
	localparam int MASK_BOTTOM = 4;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic                       kind;
		logic [SLOT_W-1:0]          slot;
		logic signed [POS_W-1:0]    box_x;
		logic signed [POS_W-1:0]    box_y;
		logic [SIZE_W-1:0]          box_w;
		logic [SIZE_W-1:0]          box_h;
		logic signed [VEL_W-1:0]    vel_x;
		logic signed [VEL_W-1:0]    vel_y;
		logic [MASK_W-1:0]          solid_mask;
		logic [TAG_W-1:0]           owner_tag;
	} in_item_t;

	typedef struct packed {
		logic                       floor_hit;
		logic                       ceiling_hit;
		logic                       right_side_hit;
		logic                       left_side_hit;
		logic [IDX_W-1:0]           below_slot;
		logic [IDX_W-1:0]           above_slot;
		logic [IDX_W-1:0]           right_slot;
		logic [IDX_W-1:0]           left_slot;
		logic signed [POS_W-1:0]    floor_top;
		logic signed [POS_W-1:0]    wall_left_edge;
		logic signed [POS_W-1:0]    wall_right_edge;
		logic signed [POS_W-1:0]    ceiling_bottom;
	} out_item_t;

	localparam out_item_t RESULT_NONE = '{
		floor_hit:       1'b0,
		ceiling_hit:     1'b0,
		right_side_hit:  1'b0,
		left_side_hit:   1'b0,
		below_slot:      NO_SLOT,
		above_slot:      NO_SLOT,
		right_slot:      NO_SLOT,
		left_slot:       NO_SLOT,
		floor_top:       '0,
		wall_left_edge:  '0,
		wall_right_edge: '0,
		ceiling_bottom:  '0
	};

	typedef struct packed {
		logic signed [POS_W-1:0]    x;
		logic signed [POS_W-1:0]    y;
		logic [SIZE_W-1:0]          w;
		logic [SIZE_W-1:0]          h;
	} box_row_t;

	typedef struct packed {
		logic signed [VEL_W-1:0]    vx;
		logic signed [VEL_W-1:0]    vy;
		logic [MASK_W-1:0]          mask;
		logic [TAG_W-1:0]           tag;
	} motion_row_t;

	// query box held for the length of a scan
	typedef struct packed {
		logic signed [EXT_W-1:0]    qx;
		logic signed [EXT_W-1:0]    qy;
		logic signed [EXT_W-1:0]    qr;
		logic signed [EXT_W-1:0]    qb;
		logic signed [VEL_W-1:0]    qvx;
		logic signed [VEL_W-1:0]    qvy;
		logic signed [SLACK_W-1:0]  qvy_slack;
		logic [TAG_W-1:0]           tag;
		logic [MARGIN_W-1:0]        margin;
	} qctx_t;

	// control that travels with each slot read
	typedef struct packed {
		logic                       vld;
		logic                       last;
		logic                       live;
		logic [IDX_W-1:0]           idx;
	} scan_tag_t;

	// classified contact of one slot
	typedef struct packed {
		logic                       vld;
		logic                       last;
		logic [IDX_W-1:0]           idx;
		logic                       top;
		logic                       lft;
		logic                       rgt;
		logic                       bot;
		logic                       bot_solid;
		logic [POS_W-1:0]           ftop;
		logic [POS_W-1:0]           wle;
		logic [POS_W-1:0]           wre;
		logic [POS_W-1:0]           cbot;
	} hit_t;

endpackage

>>> sv/acsf_ram.sv
module acsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/acsf_slot_eval.sv
module acsf_slot_eval (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acsf_pkg::scan_tag_t    tag_s1,
	input  acsf_pkg::box_row_t     box_s1,
	input  acsf_pkg::motion_row_t  mot_s1,
	input  acsf_pkg::qctx_t        qctx,
	output acsf_pkg::hit_t         hit
);

	import acsf_pkg::*;

	// stage 2: slot edges, top and left edge differences, velocity tests
	logic signed [EXT_W-1:0] bx_e, by_e, bw_e, bh_e;
	logic signed [EXT_W-1:0] br_c, bb_c, dt_c, dl_c;
	logic                    elig_c;

	assign bx_e   = EXT_W'(box_s1.x);
	assign by_e   = EXT_W'(box_s1.y);
	assign bw_e   = EXT_W'(box_s1.w);
	assign bh_e   = EXT_W'(box_s1.h);
	assign br_c   = bx_e + bw_e;
	assign bb_c   = by_e + bh_e;
	assign dt_c   = qctx.qb - by_e;
	assign dl_c   = qctx.qr - bx_e;
	assign elig_c = tag_s1.live & mot_s1.mask[MASK_SOLID] & (mot_s1.tag != qctx.tag);

	logic                    vld_s2, last_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic                    elig_s2;
	logic signed [EXT_W-1:0] br_s2, bb_s2, dt_s2, dl_s2;
	logic [POS_W-1:0]        bx_s2, by_s2;
	logic [MASK_W-1:0]       mask_s2;
	logic                    topv_s2, lv_s2, rv_s2, bv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= tag_s1.vld;
			last_s2 <= tag_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= tag_s1.idx;
		elig_s2 <= elig_c;
		br_s2   <= br_c;
		bb_s2   <= bb_c;
		dt_s2   <= dt_c;
		dl_s2   <= dl_c;
		bx_s2   <= box_s1.x;
		by_s2   <= box_s1.y;
		mask_s2 <= mot_s1.mask;
		topv_s2 <= qctx.qvy_slack >= mot_s1.vy;
		lv_s2   <= qctx.qvx >= mot_s1.vx;
		rv_s2   <= qctx.qvx <= mot_s1.vx;
		bv_s2   <= qctx.qvy <= mot_s1.vy;
	end

	// stage 3: remaining differences, top and left gaps
	logic signed [EXT_W-1:0] dr_c, db_c, gt_c, gl_c;

	assign dr_c = br_s2 - qctx.qx;
	assign db_c = bb_s2 - qctx.qy;
	assign gt_c = dt_s2[EXT_W-1] ? -dt_s2 : dt_s2;
	assign gl_c = dl_s2[EXT_W-1] ? -dl_s2 : dl_s2;

	logic                    vld_s3, last_s3;
	logic [IDX_W-1:0]        idx_s3;
	logic                    ovl_s3;
	logic signed [EXT_W-1:0] dr_s3, db_s3, gt_s3, gl_s3;
	logic [POS_W-1:0]        bx_s3, by_s3, br_s3, bb_s3;
	logic [MASK_W-1:0]       mask_s3;
	logic                    topv_s3, lv_s3, rv_s3, bv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		ovl_s3  <= elig_s2 & ~dt_s2[EXT_W-1] & ~dl_s2[EXT_W-1];
		dr_s3   <= dr_c;
		db_s3   <= db_c;
		gt_s3   <= gt_c;
		gl_s3   <= gl_c;
		bx_s3   <= bx_s2;
		by_s3   <= by_s2;
		br_s3   <= br_s2[POS_W-1:0];
		bb_s3   <= bb_s2[POS_W-1:0];
		mask_s3 <= mask_s2;
		topv_s3 <= topv_s2;
		lv_s3   <= lv_s2;
		rv_s3   <= rv_s2;
		bv_s3   <= bv_s2;
	end

	// classify in priority top, left face, right face, bottom
	logic signed [EXT_W-1:0] gr_c, gb_c, m_e;
	logic                    ovl_c, top_c, lft_c, rgt_c, bot_c;

	assign gr_c  = dr_s3[EXT_W-1] ? -dr_s3 : dr_s3;
	assign gb_c  = db_s3[EXT_W-1] ? -db_s3 : db_s3;
	assign m_e   = EXT_W'(qctx.margin);
	assign ovl_c = ovl_s3 & ~dr_s3[EXT_W-1] & ~db_s3[EXT_W-1];

	assign top_c = (gt_s3 <= m_e) && (gt_s3 <= gl_s3) && (gt_s3 <= gr_c) &&
		(gt_s3 <= gb_c) && topv_s3 && mask_s3[MASK_TOP];
	assign lft_c = (gl_s3 <= m_e) && (gl_s3 <= gr_c) && (gl_s3 <= gb_c) &&
		lv_s3 && mask_s3[MASK_LEFT];
	assign rgt_c = (gr_c <= m_e) && (gr_c <= gb_c) && rv_s3 && mask_s3[MASK_RIGHT];
	assign bot_c = (gb_c <= m_e) && bv_s3;

	assign hit.vld       = vld_s3;
	assign hit.last      = last_s3;
	assign hit.idx       = idx_s3;
	assign hit.top       = ovl_c & top_c;
	assign hit.lft       = ovl_c & ~top_c & lft_c;
	assign hit.rgt       = ovl_c & ~top_c & ~lft_c & rgt_c;
	assign hit.bot       = ovl_c & ~top_c & ~lft_c & ~rgt_c & bot_c;
	assign hit.bot_solid = mask_s3[MASK_BOTTOM];
	assign hit.ftop      = by_s3;
	assign hit.wle       = bx_s3;
	assign hit.wre       = br_s3;
	assign hit.cbot      = bb_s3;

endmodule

>>> sv/aabb_contact_side_finder_unit.sv
// Box contact side finder.
// Input items arrive on cmd and are taken at a clock edge with start high and
// busy low. A write item (kind write) stores one slot and gives no result;
// writes to slots at or beyond ENTRIES are dropped.
// A query item scans the stored slots one per cycle out of the box and motion
// RAMs, then an evaluate pipe classifies each slot and the last
// match per side wins. With D = min(ENTRIES, 64) stored slots, done is high
// for exactly one cycle once the last of the D slots has been classified, and
// result holds the outcome; busy is low in that cycle. No new item is taken
// while a query runs, and its scan is paced by the one-read-a-cycle RAM port.
// The receiver cannot stall: result is valid only while done is high.
// The contact margin register lives at byte address 0 of the APB port, which
// is always ready; write it only while busy is low.
// Reset clears the margin to 12 and all slot valid bits, so every slot reads
// as empty and non-solid until written; no clearing pass is needed.
module aabb_contact_side_finder_unit #(
	parameter int ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  acsf_pkg::in_item_t                cmd,
	output logic                              done,
	output acsf_pkg::out_item_t               result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [acsf_pkg::ADDR_W-1:0]       paddr,
	input  logic [acsf_pkg::DATA_W-1:0]       pwdata,
	output logic [acsf_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	import acsf_pkg::*;

	// only slots reachable by the slot field are stored
	localparam int DEPTH = (ENTRIES < SLOT_SPAN) ? ENTRIES : SLOT_SPAN;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       cnt_q;
	logic                done_q;
	out_item_t           acc_q;
	scan_tag_t           tag_s1;
	qctx_t               qctx_q;
	logic [DEPTH-1:0]    live_q;
	logic [MARGIN_W-1:0] margin_q;

	logic                accept, wr_en, in_range, last_addr;
	logic [0:0]          reg_idx;
	box_row_t            box_wr, box_s1;
	motion_row_t         mot_wr, mot_s1;
	hit_t                hit;
	logic signed [EXT_W-1:0] qx_e, qy_e;

	assign accept    = start & ~busy;
	assign in_range  = {1'b0, cmd.slot} < IDX_W'(DEPTH);
	assign wr_en     = accept && (cmd.kind == KIND_WRITE) && in_range;
	assign last_addr = cnt_q == AW'(DEPTH - 1);
	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign result    = acc_q;

	// configuration port
	assign reg_idx = 1'(paddr >> 2);
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_MARGIN) ? DATA_W'(margin_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_MARGIN) begin
			margin_q <= pwdata[MARGIN_W-1:0];
		end
	end

	// slot storage
	assign box_wr = '{x: cmd.box_x, y: cmd.box_y, w: cmd.box_w, h: cmd.box_h};
	assign mot_wr = '{vx: cmd.vel_x, vy: cmd.vel_y, mask: cmd.solid_mask,
		tag: cmd.owner_tag};

	acsf_ram #(
		.WIDTH ($bits(box_row_t)),
		.DEPTH (DEPTH)
	) u_box_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.slot[AW-1:0]),
		.wdata (box_wr),
		.raddr (cnt_q),
		.rdata (box_s1)
	);

	acsf_ram #(
		.WIDTH ($bits(motion_row_t)),
		.DEPTH (DEPTH)
	) u_motion_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd.slot[AW-1:0]),
		.wdata (mot_wr),
		.raddr (cnt_q),
		.rdata (mot_s1)
	);

	// unwritten slots read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (wr_en) begin
			live_q[cmd.slot[AW-1:0]] <= 1'b1;
		end
	end

	// latch the query box at accept
	assign qx_e = EXT_W'(cmd.box_x);
	assign qy_e = EXT_W'(cmd.box_y);

	always_ff @(posedge clk) begin
		if (accept && cmd.kind == KIND_QUERY) begin
			qctx_q.qx        <= qx_e;
			qctx_q.qy        <= qy_e;
			qctx_q.qr        <= qx_e + EXT_W'(cmd.box_w);
			qctx_q.qb        <= qy_e + EXT_W'(cmd.box_h);
			qctx_q.qvx       <= cmd.vel_x;
			qctx_q.qvy       <= cmd.vel_y;
			qctx_q.qvy_slack <= SLACK_W'(cmd.vel_y) + SLACK_W'(VY_SLACK);
			qctx_q.tag       <= cmd.owner_tag;
			qctx_q.margin    <= margin_q;
		end
	end

	acsf_slot_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (tag_s1),
		.box_s1 (box_s1),
		.mot_s1 (mot_s1),
		.qctx   (qctx_q),
		.hit    (hit)
	);

	// scan sequencer and result accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			tag_s1  <= '0;
			acc_q   <= RESULT_NONE;
		end else begin
			done_q     <= (state_q == ST_DRAIN) && hit.vld && hit.last;
			tag_s1.vld <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.kind == KIND_QUERY) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						acc_q   <= RESULT_NONE;
					end
				end
				ST_SCAN: begin
					tag_s1.last <= last_addr;
					tag_s1.live <= live_q[cnt_q];
					tag_s1.idx  <= IDX_W'(cnt_q);
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (hit.vld && hit.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (hit.vld) begin
				if (hit.top) begin
					acc_q.floor_hit  <= 1'b1;
					acc_q.below_slot <= hit.idx;
					acc_q.floor_top  <= hit.ftop;
				end
				if (hit.lft) begin
					acc_q.right_side_hit <= 1'b1;
					acc_q.right_slot     <= hit.idx;
					acc_q.wall_left_edge <= hit.wle;
				end
				if (hit.rgt) begin
					acc_q.left_side_hit   <= 1'b1;
					acc_q.left_slot       <= hit.idx;
					acc_q.wall_right_edge <= hit.wre;
				end
				if (hit.bot) begin
					acc_q.above_slot <= hit.idx;
					if (hit.bot_solid) begin
						acc_q.ceiling_hit    <= 1'b1;
						acc_q.ceiling_bottom <= hit.cbot;
					end
				end
			end
		end
	end

endmodule
